// ===== src/u8v_pkg.sv =====
// shared types and constants for the utf-8 validating decoder
package u8v_pkg;

  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_E0    = 8'hE0;
  localparam logic [7:0] LEAD3_ED    = 8'hED;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_F0    = 8'hF0;
  localparam logic [7:0] LEAD4_F4    = 8'hF4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] CONT_MIN_E0 = 8'hA0;
  localparam logic [7:0] CONT_MAX_ED = 8'h9F;
  localparam logic [7:0] CONT_MIN_F0 = 8'h90;
  localparam logic [7:0] CONT_MAX_F4 = 8'h8F;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [9:0] SURR_HI     = 10'h01B;

  typedef enum logic [1:0] {
    ST_CODE_POINT    = 2'd0,
    ST_MALFORMED     = 2'd1,
    ST_END_AFTER_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  rem;
    logic [20:0] partial;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic        await_second;
    logic        failed;
  } dec_state_t;

  typedef struct packed {
    logic [20:0] code_point;
    status_t     status;
    logic        end_flag;
  } result_t;

  localparam dec_state_t STATE_RESET = '{
    rem: 2'd0, partial: 21'd0, lo: CONT_MIN, hi: CONT_MAX,
    await_second: 1'b0, failed: 1'b0
  };

endpackage

// ===== src/u8v_decode.sv =====
// combinational decode of one byte against the current sequence state
module u8v_decode (
  input  u8v_pkg::dec_state_t st,
  input  logic [7:0]          data_byte,
  input  logic                stream_end,
  output u8v_pkg::dec_state_t st_nxt,
  output logic                res_valid,
  output u8v_pkg::result_t    res
);
  import u8v_pkg::*;

  dec_state_t  st_calc;
  logic        err;
  logic        seq_start;
  logic [7:0]  lo;
  logic [7:0]  hi;
  logic [20:0] part_shift;
  logic [1:0]  rem_dec;

  always_comb begin
    st_calc    = st;
    err        = 1'b0;
    seq_start  = 1'b0;
    res_valid  = 1'b0;
    res        = '{code_point: 21'd0, status: ST_CODE_POINT, end_flag: stream_end};
    lo         = st.await_second ? st.lo : CONT_MIN;
    hi         = st.await_second ? st.hi : CONT_MAX;
    part_shift = {st.partial[14:0], data_byte[5:0]};
    rem_dec    = st.rem - 2'd1;

    if (st.failed) begin
      if (stream_end) begin
        res_valid  = 1'b1;
        res.status = ST_END_AFTER_ERR;
      end
    end else if (st.rem == 2'd0) begin
      if (data_byte <= ASCII_MAX) begin
        res_valid      = 1'b1;
        res.code_point = {13'd0, data_byte};
      end else begin
        seq_start = 1'b1;
        if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          st_calc.rem     = 2'd1;
          st_calc.partial = {16'd0, data_byte[4:0]};
          st_calc.lo      = CONT_MIN;
          st_calc.hi      = CONT_MAX;
        end else if (data_byte == LEAD3_E0) begin
          st_calc.rem     = 2'd2;
          st_calc.partial = 21'd0;
          st_calc.lo      = CONT_MIN_E0;
          st_calc.hi      = CONT_MAX;
        end else if (data_byte == LEAD3_ED) begin
          st_calc.rem     = 2'd2;
          st_calc.partial = {17'd0, data_byte[3:0]};
          st_calc.lo      = CONT_MIN;
          st_calc.hi      = CONT_MAX_ED;
        end else if (data_byte > LEAD3_E0 && data_byte <= LEAD3_MAX) begin
          st_calc.rem     = 2'd2;
          st_calc.partial = {17'd0, data_byte[3:0]};
          st_calc.lo      = CONT_MIN;
          st_calc.hi      = CONT_MAX;
        end else if (data_byte == LEAD4_F0) begin
          st_calc.rem     = 2'd3;
          st_calc.partial = 21'd0;
          st_calc.lo      = CONT_MIN_F0;
          st_calc.hi      = CONT_MAX;
        end else if (data_byte == LEAD4_F4) begin
          st_calc.rem     = 2'd3;
          st_calc.partial = {18'd0, data_byte[2:0]};
          st_calc.lo      = CONT_MIN;
          st_calc.hi      = CONT_MAX_F4;
        end else if (data_byte > LEAD4_F0 && data_byte < LEAD4_F4) begin
          st_calc.rem     = 2'd3;
          st_calc.partial = {18'd0, data_byte[2:0]};
          st_calc.lo      = CONT_MIN;
          st_calc.hi      = CONT_MAX;
        end else begin
          seq_start = 1'b0;
          err       = 1'b1;
        end
        st_calc.await_second = seq_start;
        // lead byte as the stream's last byte is a truncation
        if (seq_start && stream_end) begin
          err = 1'b1;
        end
      end
    end else begin
      if (data_byte[7:6] != 2'b10 || data_byte < lo || data_byte > hi) begin
        err = 1'b1;
      end else begin
        st_calc.await_second = 1'b0;
        st_calc.partial      = part_shift;
        st_calc.rem          = rem_dec;
        if (rem_dec == 2'd0) begin
          res_valid       = 1'b1;
          res.code_point  = part_shift;
          st_calc.partial = 21'd0;
        end else if (stream_end) begin
          err = 1'b1;
        end
      end
    end

    if (err) begin
      st_calc.rem          = 2'd0;
      st_calc.partial      = 21'd0;
      st_calc.await_second = 1'b0;
      st_calc.failed       = 1'b1;
      res_valid            = 1'b1;
      res.status           = ST_MALFORMED;
      res.code_point       = 21'd0;
    end

    // every last byte gives a result and starts a fresh stream
    st_nxt = stream_end ? STATE_RESET : st_calc;
  end

endmodule

// ===== src/u8v_out_buf.sv =====
// two-entry result buffer: output register plus skid register
module u8v_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8v_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output u8v_pkg::result_t out_data
);
  import u8v_pkg::*;

  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t out_data_r;
  result_t out_data_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t skid_data_r;
  result_t skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      // output held: park the new word
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/utf8_validating_decoder_top.sv =====
// Strict UTF-8 validating decoder, one byte per word on the input channel.
// Input: in_data_byte with in_stream_end on the last byte of a stream.
// Output: out_code_point, out_status (0 code point, 1 malformed, 2 end
// marker after an earlier error) and out_end_flag.
// A complete sequence gives one word carrying the code point; lead and
// middle bytes give no word. The first malformed or truncated sequence gives
// one malformed word, later bytes are dropped until the last byte, which
// always gives a word with out_end_flag set and returns the decoder to its
// starting state.
// Each word is registered in the output buffer when its byte is taken.
// Throughput: one byte per cycle while in_stall is low, set by the single
// decode stage between the sequence state register and the output register.
// Receiver stall: a two-entry output buffer absorbs one extra word, so
// in_stall rises only when a word waits in the second entry.
// Reset (rst_n low, synchronous) clears the sequence state and empties the
// output buffer.
module utf8_validating_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] out_code_point,
  output logic [1:0]  out_status,
  output logic        out_end_flag
);
  import u8v_pkg::*;

  dec_state_t st_r;
  dec_state_t st_nxt;
  logic       accept;
  logic       res_valid;
  result_t    res;
  result_t    out_data;
  logic       buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  u8v_decode u_decode (
    .st         (st_r),
    .data_byte  (in_data_byte),
    .stream_end (in_stream_end),
    .st_nxt     (st_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  u8v_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_code_point = out_data.code_point;
  assign out_status     = out_data.status;
  assign out_end_flag   = out_data.end_flag;

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_stream_end) |=> (st_r.rem == 2'd0 && !st_r.failed))
    else $error("state not cleared after last byte");

  a_scalar_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CODE_POINT) |->
      (out_code_point <= CP_MAX && out_code_point[20:11] != SURR_HI))
    else $error("code point out of range or surrogate");

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_CODE_POINT) |-> (out_code_point == 21'd0))
    else $error("nonzero code point on error word");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_END_AFTER_ERR) |-> out_end_flag)
    else $error("end marker without end flag");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");
`endif

endmodule

// ===== tb/utf8_validating_decoder_top_tb.sv =====
// stimulus, prediction and checking for the utf-8 validating decoder
`timescale 1ns / 100ps

module utf8_validating_decoder_top_tb;
  import u8v_pkg::*;

  class u8_decode_checker;
    result_t     expected_words[$];
    logic [1:0]  seq_left;
    logic [20:0] seq_bits;
    logic [7:0]  first_lo;
    logic [7:0]  first_hi;
    logic        want_first;
    logic        in_error;
    int          fail_count;
    int          live_bytes;
    int          streams_done;
    int          tally[3];

    function new();
      restart();
    endfunction

    function void restart();
      seq_left   = 2'd0;
      seq_bits   = 21'd0;
      first_lo   = CONT_MIN;
      first_hi   = CONT_MAX;
      want_first = 1'b0;
      in_error   = 1'b0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void expect_word(logic [20:0] cp, status_t st, logic last);
      result_t w;
      w.code_point = cp;
      w.status     = st;
      w.end_flag   = last;
      expected_words.insert(expected_words.size(), w);
      if (last) begin
        restart();
        streams_done++;
      end
    endfunction

    function void flag_malformed(logic last);
      seq_left   = 2'd0;
      seq_bits   = 21'd0;
      want_first = 1'b0;
      in_error   = 1'b1;
      expect_word(21'd0, ST_MALFORMED, last);
    endfunction

    function void open_seq(logic [1:0] n, logic [20:0] bits, logic [7:0] lo, logic [7:0] hi);
      seq_left   = n;
      seq_bits   = bits;
      first_lo   = lo;
      first_hi   = hi;
      want_first = 1'b1;
    endfunction

    // works out the word (if any) caused by one accepted byte
    function void note_byte(logic [7:0] b, logic last);
      logic [7:0] lo;
      logic [7:0] hi;
      live_bytes++;
      if (in_error) begin
        if (last) begin
          expect_word(21'd0, ST_END_AFTER_ERR, 1'b1);
        end
        return;
      end
      if (seq_left == 2'd0) begin
        if (b <= ASCII_MAX) begin
          expect_word({13'd0, b}, ST_CODE_POINT, last);
          return;
        end
        if (b >= LEAD2_MIN && b <= LEAD2_MAX)
          open_seq(2'd1, {13'd0, b & 8'h1F}, CONT_MIN, CONT_MAX);
        else if (b == LEAD3_E0) open_seq(2'd2, 21'd0, CONT_MIN_E0, CONT_MAX);
        else if (b == LEAD3_ED) open_seq(2'd2, {13'd0, b & 8'h0F}, CONT_MIN, CONT_MAX_ED);
        else if (b > LEAD3_E0 && b <= LEAD3_MAX)
          open_seq(2'd2, {13'd0, b & 8'h0F}, CONT_MIN, CONT_MAX);
        else if (b == LEAD4_F0) open_seq(2'd3, 21'd0, CONT_MIN_F0, CONT_MAX);
        else if (b == LEAD4_F4) open_seq(2'd3, {13'd0, b & 8'h07}, CONT_MIN, CONT_MAX_F4);
        else if (b > LEAD4_F0 && b < LEAD4_F4)
          open_seq(2'd3, {13'd0, b & 8'h07}, CONT_MIN, CONT_MAX);
        else begin
          flag_malformed(last);
          return;
        end
        // lead byte as the last byte is a truncated sequence
        if (last) flag_malformed(1'b1);
        return;
      end
      lo = want_first ? first_lo : CONT_MIN;
      hi = want_first ? first_hi : CONT_MAX;
      if (b[7:6] != 2'b10 || b < lo || b > hi) begin
        flag_malformed(last);
        return;
      end
      want_first = 1'b0;
      seq_bits   = {seq_bits[14:0], b[5:0]};
      seq_left   = seq_left - 2'd1;
      if (seq_left == 2'd0) begin
        expect_word(seq_bits, ST_CODE_POINT, last);
        seq_bits = 21'd0;
      end else if (last) begin
        flag_malformed(1'b1);
      end
    endfunction

    function void mismatch(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    function void check_word(logic [20:0] cp, logic [1:0] st, logic ef);
      result_t w;
      if (expected_words.size() == 0) begin
        mismatch($sformatf("unexpected word cp=%h status=%0d end=%0d", cp, st, ef));
        return;
      end
      w = expected_words.pop_front();
      if (cp !== w.code_point || st !== w.status || ef !== w.end_flag)
        mismatch($sformatf("expected cp=%h status=%0d end=%0d, got cp=%h status=%0d end=%0d",
                           w.code_point, w.status, w.end_flag, cp, st, ef));
      else
        tally[w.status]++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [20:0] out_code_point;
  logic [1:0]  out_status;
  logic        out_end_flag;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [7:0]  stream_q[$];

  u8_decode_checker board = new();

  utf8_validating_decoder_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_stream_end  (in_stream_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_status     (out_status),
    .out_end_flag   (out_end_flag)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word(out_code_point, out_status, out_end_flag);
  end

  task send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_stream_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, last);
  endtask

  task send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  // appends the n low bytes of v, most significant first
  task add_bytes(input int n, input logic [31:0] v);
    for (int i = n - 1; i >= 0; i--)
      stream_q.insert(stream_q.size(), v[8*i +: 8]);
  endtask

  task add_char(input int min_len, output int len);
    logic [20:0] cp;
    int lo;
    int hi;
    len = $urandom_range(min_len, 4);
    case (len)
      1: begin lo = 'h0; hi = 'h7F; end
      2: begin lo = 'h80; hi = 'h7FF; end
      3: begin
        // stay clear of the surrogate block
        if ($urandom_range(0, 1)) begin lo = 'h800; hi = 'hD7FF; end
        else begin lo = 'hE000; hi = 'hFFFF; end
      end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    case ($urandom_range(0, 7))
      0: cp = 21'(lo);
      1: cp = 21'(hi);
      default: cp = 21'($urandom_range(hi, lo));
    endcase
    case (len)
      1: add_bytes(1, 32'({1'b0, cp[6:0]}));
      2: add_bytes(2, 32'({3'b110, cp[10:6], 2'b10, cp[5:0]}));
      3: add_bytes(3, 32'({4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0]}));
      default: add_bytes(4, {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                             2'b10, cp[5:0]});
    endcase
  endtask

  task add_broken();
    int len;
    logic [7:0] junk;
    logic [7:0] second;
    junk = 8'($urandom_range(0, 1) ? $urandom_range(0, 8'h7F) : $urandom_range(8'hC0, 8'hFF));
    case ($urandom_range(0, 4))
      0: add_bytes(1, $urandom_range(0, 255));
      1: add_bytes(1, $urandom_range(0, 1) ? $urandom_range(8'h80, 8'hC1)
                                           : $urandom_range(8'hF5, 8'hFF));
      2: begin
        // overlong, surrogate or out-of-range second byte
        case ($urandom_range(0, 3))
          0: begin
            second = 8'($urandom_range(CONT_MIN, CONT_MIN_E0 - 1));
            add_bytes(2, 32'({LEAD3_E0, second}));
          end
          1: begin
            second = 8'($urandom_range(CONT_MAX_ED + 1, CONT_MAX));
            add_bytes(2, 32'({LEAD3_ED, second}));
          end
          2: begin
            second = 8'($urandom_range(CONT_MIN, CONT_MIN_F0 - 1));
            add_bytes(2, 32'({LEAD4_F0, second}));
          end
          default: begin
            second = 8'($urandom_range(CONT_MAX_F4 + 1, CONT_MAX));
            add_bytes(2, 32'({LEAD4_F4, second}));
          end
        endcase
      end
      3: begin
        add_char(2, len);
        stream_q[stream_q.size() - len + $urandom_range(1, len - 1)] = junk;
      end
      default: begin
        add_char(2, len);
        repeat ($urandom_range(1, len - 1)) void'(stream_q.pop_back());
      end
    endcase
  endtask

  task make_stream();
    int n;
    int len;
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) add_bytes(1, $urandom_range(0, 255));
      return;
    end
    n = $urandom_range(1, 10);
    repeat (n) begin
      if ($urandom_range(0, 99) < 85) add_char(1, len);
      else add_broken();
    end
    // cut the tail now and then so the stream may end inside a sequence
    if ($urandom_range(0, 9) == 0 && stream_q.size() > 1) void'(stream_q.pop_back());
  endtask

  task run_phase(input int idle_pct, input int stall_pct, input int n);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = board.live_bytes + n;
    while (board.live_bytes < target) begin
      make_stream();
      send_stream();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct  = 8;
    recv_stall_pct = 54;

    // field extremes: first and last scalar of lengths 1, 2 and 4, first of length 3 and D7FF
    add_bytes(2, 32'h007F);
    add_bytes(2, 32'hC280);
    add_bytes(2, 32'hDFBF);
    add_bytes(3, 32'hE0A080);
    add_bytes(3, 32'hED9FBF);
    add_bytes(4, 32'hF0908080);
    add_bytes(4, 32'hF48FBFBF);
    send_stream();
    // bad lead, ignored byte, then end marker after the error
    add_bytes(3, 32'hC1FF41);
    send_stream();
    // surrogate continuation on the last byte
    add_bytes(2, 32'hEDA0);
    send_stream();
    // stream ends inside a sequence
    add_bytes(2, 32'hE180);
    send_stream();

    run_phase(8, 54, 600);
    run_phase(54, 8, 600);
    run_phase(0, 0, 500);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes over %0d streams, idling on each side then on neither",
             board.live_bytes, board.streams_done);
    $display("words matched: %0d code points, %0d malformed, %0d end markers; %0d bad",
             board.tally[ST_CODE_POINT], board.tally[ST_MALFORMED],
             board.tally[ST_END_AFTER_ERR], board.fail_count);
    if (board.fail_count == 0 && board.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words outstanding", board.pending());
    $display("== FAIL ==");
    $finish;
  end

endmodule
